@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked concurrent assertions with reset gating
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while out of reset
`define CLSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising edge while out of reset
`define CLSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/clsp_pkg.sv @@
// ----------------------------------------------------------------------------
// clsp_pkg
// shared codes, keyword tables and result type for the control line parser
// ----------------------------------------------------------------------------
`default_nettype none

package clsp_pkg;

  // result kinds
  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_CMD      = 4'd1;
  localparam logic [3:0] KIND_ARG      = 4'd2;
  localparam logic [3:0] KIND_OUTPUT   = 4'd3;
  localparam logic [3:0] KIND_IGN_BYTE = 4'd4;
  localparam logic [3:0] KIND_IGN_END  = 4'd5;
  localparam logic [3:0] KIND_BEGIN    = 4'd6;
  localparam logic [3:0] KIND_OK       = 4'd7;
  localparam logic [3:0] KIND_ERROR    = 4'd8;
  localparam logic [3:0] KIND_NOTIFY   = 4'd9;
  localparam logic [3:0] KIND_EXIT     = 4'd10;

  // special characters
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // keyword indexes
  localparam logic [1:0] KW_BEGIN = 2'd0;
  localparam logic [1:0] KW_EXIT  = 2'd1;
  localparam logic [1:0] KW_END   = 2'd2;
  localparam logic [1:0] KW_ERROR = 2'd3;
  localparam int unsigned KW_COUNT = 4;

  // longest keyword, matcher gives up beyond it
  localparam logic [3:0] KW_MAX = 4'd12;

  // keyword text padded to 16 characters with zeros
  localparam logic [7:0] KW_TEXT [KW_COUNT][16] = '{
    '{8'h25, 8'h62, 8'h65, 8'h67, 8'h69, 8'h6e, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h65, 8'h78, 8'h69, 8'h74, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h62, 8'h65, 8'h67, 8'h69, 8'h6e, 8'h25, 8'h65,
      8'h6e, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h62, 8'h65, 8'h67, 8'h69, 8'h6e, 8'h25, 8'h65,
      8'h72, 8'h72, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd5, 4'd10, 4'd12};

  // one result transfer
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data_byte;
  } clsp_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/clsp_core.sv @@
// ----------------------------------------------------------------------------
// clsp_core
// parse state, keyword matcher and per-byte classification
// ----------------------------------------------------------------------------
`default_nettype none

module clsp_core import clsp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   in_byte_i,
  output clsp_result_t      result_o
);

  localparam logic [2:0] ST_GROUND     = 3'd0;
  localparam logic [2:0] ST_IGNORE     = 3'd1;
  localparam logic [2:0] ST_COMMAND    = 3'd2;
  localparam logic [2:0] ST_ARGUMENTS  = 3'd3;
  localparam logic [2:0] ST_OUT_GROUND = 3'd4;
  localparam logic [2:0] ST_OUTPUT     = 3'd5;

  logic [2:0] state_q, state_d;
  logic [3:0] pos_q, pos_d;
  logic       failed_q, failed_d;
  logic [3:0] alive_q, alive_d;
  logic       halted_q, halted_d;

  logic [3:0] keep;
  logic [3:0] hit;
  logic [3:0] kind;
  logic       stored;

  // keywords still alive after this character
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      keep[k] = alive_q[k] && (KW_LEN[k] > pos_q) && (KW_TEXT[k][pos_q] == in_byte_i);
      hit[k]  = !failed_q && alive_q[k] && (pos_q == KW_LEN[k]);
    end
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    failed_d = failed_q;
    alive_d  = alive_q;
    halted_d = halted_q;
    kind     = KIND_NONE;
    stored   = 1'b0;

    if (!halted_q) begin
      case (state_q)
        ST_IGNORE: begin
          if (in_byte_i == CH_LF) begin
            kind    = KIND_IGN_END;
            state_d = ST_GROUND;
          end else begin
            kind   = KIND_IGN_BYTE;
            stored = 1'b1;
          end
        end
        ST_COMMAND, ST_ARGUMENTS: begin
          if (in_byte_i == CH_LF) begin
            // line end: begin keeps the command text for the response lines
            if (hit[KW_BEGIN]) begin
              kind    = KIND_BEGIN;
              state_d = ST_OUT_GROUND;
            end else if (hit[KW_EXIT]) begin
              kind     = KIND_EXIT;
              halted_d = 1'b1;
            end else begin
              kind     = hit[KW_END] ? KIND_OK : (hit[KW_ERROR] ? KIND_ERROR : KIND_NOTIFY);
              pos_d    = '0;
              failed_d = 1'b0;
              alive_d  = '1;
              state_d  = ST_GROUND;
            end
          end else if (state_q == ST_COMMAND && in_byte_i == CH_SPACE) begin
            state_d = ST_ARGUMENTS;
          end else begin
            kind   = (state_q == ST_COMMAND) ? KIND_CMD : KIND_ARG;
            stored = 1'b1;
          end
        end
        ST_OUT_GROUND: begin
          if (in_byte_i == CH_PERCENT) begin
            state_d = ST_COMMAND;
            kind    = KIND_CMD;
          end else begin
            state_d = ST_OUTPUT;
            kind    = KIND_OUTPUT;
          end
          stored = 1'b1;
        end
        ST_OUTPUT: begin
          if (in_byte_i == CH_LF) begin
            state_d = ST_OUT_GROUND;
          end
          kind   = KIND_OUTPUT;
          stored = 1'b1;
        end
        default: begin
          if (in_byte_i == CH_PERCENT) begin
            state_d = ST_COMMAND;
            kind    = KIND_CMD;
          end else begin
            state_d = ST_IGNORE;
            kind    = KIND_IGN_BYTE;
          end
          stored = 1'b1;
        end
      endcase

      if (stored) begin
        if (in_byte_i == CH_CR) begin
          kind = KIND_NONE;
        end else if (kind == KIND_CMD && !failed_q) begin
          if (pos_q >= KW_MAX) begin
            failed_d = 1'b1;
          end else begin
            alive_d = keep;
            if (keep == '0) begin
              failed_d = 1'b1;
            end else begin
              pos_d = pos_q + 4'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    result_o.kind      = kind;
    result_o.data_byte = (kind >= KIND_CMD && kind <= KIND_IGN_BYTE) ? in_byte_i : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_GROUND;
      pos_q    <= '0;
      failed_q <= 1'b0;
      alive_q  <= '1;
      halted_q <= 1'b0;
    end else if (accept_i) begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      failed_q <= failed_d;
      alive_q  <= alive_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/clsp_obuf.sv @@
// ----------------------------------------------------------------------------
// clsp_obuf
// two-entry result buffer decoupling the input from a stalled output
// ----------------------------------------------------------------------------
`default_nettype none

module clsp_obuf import clsp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire clsp_result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output clsp_result_t      out_data_o
);

  clsp_result_t mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q, count_d;
  logic         pop;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/control_line_stream_parser_top.sv @@
// ----------------------------------------------------------------------------
// control_line_stream_parser_top
// each result is registered in the result buffer before it is offered
// throughput: one byte per cycle unless buf_full; state and matcher step per byte
// the two-entry result buffer keeps input flowing while one result is held
// reset: asynchronous active low, parser returns to ground with matcher cleared
// ----------------------------------------------------------------------------
`default_nettype none

module control_line_stream_parser_top import clsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // byte input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  // classification output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      kind_o,
  output logic [7:0]      data_byte_o
);

  // every accepted byte yields exactly one result, so the buffer fill
  // alone decides whether the input side may transfer
  logic         in_accept;
  logic         buf_full;
  clsp_result_t step_result;
  clsp_result_t out_result;

  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  // parse state, keyword matcher and byte classification; the state
  // advances only on an input transfer
  clsp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_byte_i (in_byte_i),
    .result_o  (step_result)
  );

  // result registers, two deep so a held output does not stop the next byte
  clsp_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (step_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_result)
  );

  assign kind_o      = out_result.kind;
  assign data_byte_o = out_result.data_byte;

endmodule

`default_nettype wire

@@ hw/rtl/clsp_checker.sv @@
// ----------------------------------------------------------------------------
// clsp_checker
// port-level checks for the control line parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clsp_checker import clsp_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] kind_o,
  input wire logic [7:0] data_byte_o
);

  logic        out_held;
  logic        in_held;
  logic        out_event;
  logic        data_clear;
  logic [12:0] out_word;
  logic [8:0]  in_word;

  assign out_held   = out_valid_o && out_stall_i;
  assign in_held    = in_valid_i && in_stall_o;
  assign out_event  = out_valid_o && ((kind_o == KIND_NONE) || (kind_o > KIND_IGN_BYTE));
  assign data_clear = (data_byte_o == 8'h00);
  assign out_word   = {out_valid_o, kind_o, data_byte_o};
  assign in_word    = {in_valid_i, in_byte_i};

  `CLSP_ASSERT(a_kind_range, clk_i, rst_ni, !out_valid_o || kind_o <= KIND_EXIT, "bad kind")
  `CLSP_ASSERT_IMPL(a_data_zero, clk_i, rst_ni, out_event, data_clear, "data on event")
  `CLSP_ASSERT_IMPL(a_empty_no_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o, "stall while empty")
  `CLSP_ASSERT(a_out_hold, clk_i, rst_ni, out_held |=> $stable(out_word), "held result moved")
  `CLSP_ASSERT(a_in_hold, clk_i, rst_ni, in_held |=> $stable(in_word), "stalled input moved")

endmodule

bind control_line_stream_parser_top clsp_checker u_clsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_byte_i   (in_byte_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .data_byte_o (data_byte_o)
);

`default_nettype wire
